FILE: rtl/kler_pkg.sv
// Shared types and constants for the K-line echo checker and frame receiver.
// No dependencies; imported by the top level and by kler_skid (not by kler_ram).
`timescale 1ns / 1ps

package kler_pkg;

  // Echo store geometry
  localparam int unsigned ECHO_DEPTH = 64;
  localparam int unsigned ECHO_AW    = $clog2(ECHO_DEPTH);
  localparam int unsigned ECHO_CW    = $clog2(ECHO_DEPTH + 1);

  // Frame format
  localparam logic [7:0] FMT_LEN_MASK = 8'h3F;
  localparam logic [6:0] FRAME_EXTRA  = 7'd4;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_TX      = 2'd0,
    OP_RX      = 2'd1,
    OP_TIMEOUT = 2'd2
  } op_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_FRAME    = 2'd0,
    KIND_MISMATCH = 2'd1,
    KIND_ABORT    = 2'd2
  } kind_e;

  // One result word
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  byte_value;
    logic [6:0]  position;
    logic        last_byte;
    logic        checksum_ok;
  } res_t;

endpackage

FILE: rtl/kler_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies. A read during a write to the same address returns old data.
`timescale 1ns / 1ps

module kler_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/kler_skid.sv
// Two-entry output buffer (output register plus skid register) for result words.
// Depends on kler_pkg for the result word type.
`timescale 1ns / 1ps

module kler_skid (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  kler_pkg::res_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output kler_pkg::res_t out_data_o
);
  import kler_pkg::*;

  logic main_valid_q, skid_valid_q;
  res_t main_q, skid_q;
  logic pop;

  assign pop         = main_valid_q && out_ready_i;
  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  // Control: main register refills from skid first, then from input
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!main_valid_q || pop) begin
      main_valid_q <= skid_valid_q || in_valid_i;
      skid_valid_q <= 1'b0;
    end else if (in_valid_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (!main_valid_q || pop) begin
      main_q <= skid_valid_q ? skid_q : in_data_i;
    end else if (in_valid_i && !skid_valid_q) begin
      skid_q <= in_data_i;
    end
  end

endmodule

FILE: rtl/kline_echo_and_frame_receiver.sv
// K-line echo checker and KWP2000 frame receiver: top level.
// Depends on kler_pkg, kler_ram and kler_skid.
// Result words are registered in the output register, or in the skid register if it is busy.
// Throughput: one input word per cycle; the echo RAM is read every cycle at the
// next match index, with a one-entry forward of a same-cycle write.
// Input stalls only when both output registers hold words the sink has not taken.
// Reset clears all control state at once; the echo RAM is not cleared (only
// entries written in the current echo batch are ever compared), so no sweep.
`timescale 1ns / 1ps

module kline_echo_and_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] operation
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] byte_value, [14:8] position, [15] checksum_ok
  output logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  output logic        m_axis_tlast_o    // last_byte
);
  import kler_pkg::*;

  // State
  logic               echo_mode_q, echo_mode_d;
  logic [ECHO_CW-1:0] echo_count_q, echo_count_d;
  logic [ECHO_CW-1:0] echo_matched_q, echo_matched_d;
  logic               frame_active_q, frame_active_d;
  logic [6:0]         frame_total_q, frame_total_d;
  logic [6:0]         frame_index_q, frame_index_d;
  logic [7:0]         running_sum_q, running_sum_d;

  // Echo RAM access and forwarding
  logic               wr_en;
  logic [ECHO_AW-1:0] wr_addr, rd_addr;
  logic [7:0]         rd_data, fwd_data_q, expected;
  logic               fwd_hit_q;

  logic               accept, do_rx, res_valid;
  logic [7:0]         rx_byte;
  logic [ECHO_CW-1:0] cnt_base, matched_inc;
  op_e                op;
  res_t               res, out_res;

  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign op      = op_e'(s_axis_tuser_i);
  assign rx_byte = s_axis_tdata_i;
  assign cnt_base = echo_mode_q ? echo_count_q : '0;
  assign rd_addr  = echo_matched_d[ECHO_AW-1:0];
  assign expected = fwd_hit_q ? fwd_data_q : rd_data;

  kler_ram #(
    .WIDTH (8),
    .DEPTH (ECHO_DEPTH)
  ) u_echo_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (rx_byte),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Next-state and result word
  always_comb begin
    echo_mode_d    = echo_mode_q;
    echo_count_d   = echo_count_q;
    echo_matched_d = echo_matched_q;
    frame_active_d = frame_active_q;
    frame_total_d  = frame_total_q;
    frame_index_d  = frame_index_q;
    running_sum_d  = running_sum_q;
    wr_en          = 1'b0;
    wr_addr        = cnt_base[ECHO_AW-1:0];
    do_rx          = 1'b0;
    res_valid      = 1'b0;
    res            = '0;
    matched_inc    = echo_matched_q + ECHO_CW'(1);

    if (accept) begin
      case (op)
        OP_TX: begin
          // a transmit in receive mode opens a new echo batch
          if (!echo_mode_q) begin
            echo_mode_d    = 1'b1;
            echo_matched_d = '0;
            frame_active_d = 1'b0;
            frame_index_d  = '0;
            running_sum_d  = '0;
          end
          echo_count_d = cnt_base;
          if (cnt_base < ECHO_CW'(ECHO_DEPTH)) begin
            wr_en        = 1'b1;
            echo_count_d = cnt_base + ECHO_CW'(1);
          end
        end
        OP_RX: begin
          if (!echo_mode_q) begin
            do_rx = 1'b1;
          end else if (echo_matched_q >= echo_count_q) begin
            // nothing pending: leave echo mode, treat as received byte
            echo_mode_d    = 1'b0;
            echo_count_d   = '0;
            echo_matched_d = '0;
            do_rx          = 1'b1;
          end else begin
            if (expected == rx_byte) begin
              echo_matched_d = matched_inc;
            end else begin
              res_valid      = 1'b1;
              res.kind       = KIND_MISMATCH;
              res.byte_value = rx_byte;
              res.position   = 7'(echo_matched_q);
            end
            if (echo_matched_d >= echo_count_q) begin
              echo_mode_d    = 1'b0;
              echo_count_d   = '0;
              echo_matched_d = '0;
            end
          end
        end
        OP_TIMEOUT: begin
          if (!echo_mode_q && frame_active_q) begin
            frame_active_d = 1'b0;
            frame_index_d  = '0;
            running_sum_d  = '0;
            res_valid      = 1'b1;
            res.kind       = KIND_ABORT;
            res.position   = frame_index_q;
          end
        end
        default: begin
        end
      endcase
    end

    // Receive-mode framing
    if (do_rx) begin
      if (!frame_active_q) begin
        if (rx_byte[7]) begin
          frame_total_d  = 7'(rx_byte & FMT_LEN_MASK) + FRAME_EXTRA;
          frame_active_d = 1'b1;
          running_sum_d  = rx_byte;
          frame_index_d  = 7'd1;
          res_valid      = 1'b1;
          res.kind       = KIND_FRAME;
          res.byte_value = rx_byte;
          res.position   = '0;
        end
      end else begin
        res_valid      = 1'b1;
        res.kind       = KIND_FRAME;
        res.byte_value = rx_byte;
        res.position   = frame_index_q;
        if (({1'b0, frame_index_q} + 8'd1) >= {1'b0, frame_total_q}) begin
          frame_active_d  = 1'b0;
          frame_index_d   = '0;
          res.last_byte   = 1'b1;
          res.checksum_ok = (rx_byte == running_sum_q);
        end else begin
          running_sum_d = running_sum_q + rx_byte;
          frame_index_d = frame_index_q + 7'd1;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_mode_q    <= 1'b1;
      echo_count_q   <= '0;
      echo_matched_q <= '0;
      frame_active_q <= 1'b0;
      frame_total_q  <= '0;
      frame_index_q  <= '0;
      running_sum_q  <= '0;
      fwd_hit_q      <= 1'b0;
    end else begin
      echo_mode_q    <= echo_mode_d;
      echo_count_q   <= echo_count_d;
      echo_matched_q <= echo_matched_d;
      frame_active_q <= frame_active_d;
      frame_total_q  <= frame_total_d;
      frame_index_q  <= frame_index_d;
      running_sum_q  <= running_sum_d;
      fwd_hit_q      <= wr_en && (wr_addr == rd_addr);
    end
  end

  // Forwarded write data, used only when fwd_hit_q is set
  always_ff @(posedge clk_i) begin
    fwd_data_q <= rx_byte;
  end

  kler_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_res)
  );

  // Output packing
  assign m_axis_tdata_o = {out_res.checksum_ok, out_res.position, out_res.byte_value};
  assign m_axis_tuser_o = out_res.kind;
  assign m_axis_tlast_o = out_res.last_byte;

  // Assertions
  a_matched_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    echo_matched_q <= echo_count_q)
    else $error("echo match count ran past the stored count");

  a_rx_counts_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !echo_mode_q |-> (echo_count_q == '0) && (echo_matched_q == '0))
    else $error("echo counts not cleared in receive mode");

  a_no_frame_in_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    echo_mode_q |-> !frame_active_q)
    else $error("frame open while in echo mode");

  a_index_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_active_q |-> (frame_index_q < frame_total_q))
    else $error("frame index beyond frame length");

  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with empty output register");

endmodule
